>>> rtl/qlm_pkg.sv
// qlm_pkg: shared widths, status codes, register indexes and the lock entry layout
// for the queued lock manager; used by every module under rtl
`default_nettype none

package qlm_pkg;

  // table geometry
  localparam int unsigned LOCKS    = 64;
  localparam int unsigned HOSTS    = 16;
  localparam int unsigned LOCK_W   = $clog2(LOCKS);
  localparam int unsigned HOST_W   = $clog2(HOSTS);
  localparam int unsigned COUNT_W  = HOST_W + 1;
  localparam int unsigned WQ_AW    = LOCK_W + HOST_W;

  // configuration registers
  localparam int unsigned HCOUNT_W = 5;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_HOST_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MY_HOST_ID = 1'd1;

  // modulo unit, one dividend bit a step
  localparam int unsigned STEP_W = $clog2(LOCK_W + 1);

  // stream payloads
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  // commands
  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [3:0] {
    ST_GRANTED       = 4'd0,
    ST_QUEUED        = 4'd1,
    ST_ALREADY_OWNER = 4'd2,
    ST_HANDED        = 4'd3,
    ST_FREED         = 4'd4,
    ST_BAD_HOST      = 4'd5,
    ST_NOT_HOME      = 4'd6,
    ST_LOCK_FREE     = 4'd7,
    ST_NOT_OWNER     = 4'd8,
    ST_QUEUE_FULL    = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE   = 3'b001,
    FSM_DIV    = 3'b010,
    FSM_DECIDE = 3'b100
  } fsm_e;

  // one row of the lock table
  typedef struct packed {
    logic               held;
    logic [HOST_W-1:0]  owner;
    logic [HOST_W-1:0]  last;
    logic               last_vld;
    logic [HOST_W-1:0]  head;
    logic [COUNT_W-1:0] count;
  } lock_entry_t;

endpackage

`default_nettype wire

>>> rtl/qlm_mod.sv
// qlm_mod: iterative restoring modulo of the lock index by the host count,
// one dividend bit a cycle; uses qlm_pkg
`default_nettype none

module qlm_mod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [qlm_pkg::LOCK_W-1:0]   dividend_i,
  input  logic [qlm_pkg::HCOUNT_W-1:0] divisor_i,
  output logic                         busy_o,
  output logic [qlm_pkg::HCOUNT_W-1:0] rem_o
);
  import qlm_pkg::*;

  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic [LOCK_W-1:0]   shr_q, shr_d;
  logic [HCOUNT_W-1:0] rem_q, rem_d;
  logic [HCOUNT_W:0]   trial;
  logic [HCOUNT_W:0]   div_ext;

  // one shift-compare-subtract step
  always_comb begin
    trial   = {rem_q, shr_q[LOCK_W-1]};
    div_ext = {1'b0, divisor_i};
    cnt_d   = cnt_q;
    shr_d   = shr_q;
    rem_d   = rem_q;
    if (start_i) begin
      cnt_d = STEP_W'(LOCK_W);
      shr_d = dividend_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      shr_d = {shr_q[LOCK_W-2:0], 1'b0};
      if (trial >= div_ext) begin
        rem_d = HCOUNT_W'(trial - div_ext);
      end else begin
        rem_d = HCOUNT_W'(trial);
      end
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    shr_q <= shr_d;
    rem_q <= rem_d;
  end

  assign busy_o = (cnt_q != '0);
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

>>> rtl/qlm_lock_mem.sv
// qlm_lock_mem: lock table memory with one valid bit per row so that
// unwritten rows read as zero after reset; uses qlm_pkg
`default_nettype none

module qlm_lock_mem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [qlm_pkg::LOCK_W-1:0] rd_addr_i,
  output qlm_pkg::lock_entry_t       rd_data_o,
  input  logic                       wr_en_i,
  input  logic [qlm_pkg::LOCK_W-1:0] wr_addr_i,
  input  qlm_pkg::lock_entry_t       wr_data_i
);
  import qlm_pkg::*;

  lock_entry_t      mem [LOCKS];
  logic [LOCKS-1:0] vld_q;
  lock_entry_t      rd_q;
  logic             rd_vld_q;

  // row valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // storage, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

>>> rtl/qlm_wait_mem.sv
// qlm_wait_mem: per-lock circular wait queues of host ids, one write and one
// registered read port; uses qlm_pkg
`default_nettype none

module qlm_wait_mem (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [qlm_pkg::WQ_AW-1:0]  rd_addr_i,
  output logic [qlm_pkg::HOST_W-1:0] rd_data_o,
  input  logic                       wr_en_i,
  input  logic [qlm_pkg::WQ_AW-1:0]  wr_addr_i,
  input  logic [qlm_pkg::HOST_W-1:0] wr_data_i
);
  import qlm_pkg::*;

  logic [HOST_W-1:0] mem [LOCKS*HOSTS];
  logic [HOST_W-1:0] rd_q;

  // storage, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

>>> rtl/queued_lock_manager_top.sv
// queued_lock_manager_top: the result word is registered when the decide state commits,
// after the modulo steps in the subtract unit and a divide-state check that it has finished;
// one word at a time, a new word is taken only once the last one is decided, and
// the decision waits while the result word is not taken; the result register frees the input side.
// reset is asynchronous active low and clears the lock table valid bits at once,
// so no clearing pass is needed; wait queues stay undefined until written
`default_nettype none

module queued_lock_manager_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [qlm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [qlm_pkg::CFG_W-1:0]       cfg_wdata_i,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [qlm_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // lock_index, host_id
  input  logic                            s_axis_tuser,  // command
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [qlm_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // status, prior_holder,
                                                         // prior_holder_valid, next_owner
);
  import qlm_pkg::*;

  fsm_e                state_q, state_d;
  logic [HCOUNT_W-1:0] host_count_q;
  logic [HOST_W-1:0]   my_host_q;
  logic                cmd_q;
  logic [LOCK_W-1:0]   lock_q;
  logic [HOST_W-1:0]   host_q;

  logic                accept;
  logic                mod_busy;
  logic [HCOUNT_W-1:0] mod_rem;
  lock_entry_t         entry;
  lock_entry_t         entry_new;
  logic [HOST_W-1:0]   waiter;
  logic                commit;
  logic                tbl_we;
  logic                wq_we;
  logic [HOST_W-1:0]   wq_slot;

  status_e             status;
  logic [HOST_W-1:0]   prior;
  logic                prior_vld;
  logic [HOST_W-1:0]   next_owner;

  logic                out_vld_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == FSM_IDLE);
  assign commit = (state_q == FSM_DECIDE) && (!out_vld_q || m_axis_tready);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_count_q <= HCOUNT_W'(1);
      my_host_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HOST_COUNT: host_count_q <= cfg_wdata_i[HCOUNT_W-1:0];
        REG_MY_HOST_ID: my_host_q    <= cfg_wdata_i[HOST_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= s_axis_tuser;
      lock_q <= s_axis_tdata[LOCK_W-1:0];
      host_q <= s_axis_tdata[LOCK_W+HOST_W-1:LOCK_W];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE:   if (accept) state_d = FSM_DIV;
      FSM_DIV:    if (!mod_busy) state_d = FSM_DECIDE;
      FSM_DECIDE: if (commit) state_d = FSM_IDLE;
      default:    state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // shared modulo unit for the home check
  qlm_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (s_axis_tdata[LOCK_W-1:0]),
    .divisor_i  (host_count_q),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  // lock table, read on accept, written on commit
  qlm_lock_mem u_lock_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (s_axis_tdata[LOCK_W-1:0]),
    .rd_data_o (entry),
    .wr_en_i   (tbl_we),
    .wr_addr_i (lock_q),
    .wr_data_i (entry_new)
  );

  // wait queues, head read while the modulo runs
  assign wq_slot = entry.head + entry.count[HOST_W-1:0];

  qlm_wait_mem u_wait_mem (
    .clk_i     (clk_i),
    .rd_en_i   (state_q == FSM_DIV),
    .rd_addr_i ({lock_q, entry.head}),
    .rd_data_o (waiter),
    .wr_en_i   (wq_we),
    .wr_addr_i ({lock_q, wq_slot}),
    .wr_data_i (host_q)
  );

  // decision and table update
  always_comb begin
    entry_new  = entry;
    status     = ST_BAD_HOST;
    prior      = '0;
    prior_vld  = 1'b0;
    next_owner = '0;
    tbl_we     = 1'b0;
    wq_we      = 1'b0;
    if ({1'b0, host_q} >= host_count_q) begin
      status = ST_BAD_HOST;
    end else if (mod_rem != {1'b0, my_host_q}) begin
      status = ST_NOT_HOME;
    end else if (cmd_q == CMD_ACQUIRE) begin
      if (!entry.held) begin
        status          = ST_GRANTED;
        prior           = entry.last;
        prior_vld       = entry.last_vld;
        entry_new.held  = 1'b1;
        entry_new.owner = host_q;
        tbl_we          = commit;
      end else if (entry.owner == host_q) begin
        status = ST_ALREADY_OWNER;
      end else if (entry.count[COUNT_W-1]) begin
        status = ST_QUEUE_FULL;
      end else begin
        status          = ST_QUEUED;
        entry_new.count = entry.count + 1'b1;
        tbl_we          = commit;
        wq_we           = commit;
      end
    end else begin
      if (!entry.held) begin
        status = ST_LOCK_FREE;
      end else if (entry.owner != host_q) begin
        status = ST_NOT_OWNER;
      end else begin
        entry_new.last     = host_q;
        entry_new.last_vld = 1'b1;
        tbl_we             = commit;
        if (entry.count == '0) begin
          status          = ST_FREED;
          entry_new.held  = 1'b0;
          entry_new.owner = '0;
        end else begin
          status          = ST_HANDED;
          prior           = host_q;
          prior_vld       = 1'b1;
          next_owner      = waiter;
          entry_new.head  = entry.head + 1'b1;
          entry_new.count = entry.count - 1'b1;
          entry_new.owner = waiter;
        end
      end
    end
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (commit) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q <= OUT_DATA_W'({next_owner, prior_vld, prior, status});
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // a new result word only ever follows a decide cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == FSM_DECIDE))
    else $error("result word without a decision");

  // an accepted word starts the modulo unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == FSM_DIV) && mod_busy)
    else $error("modulo unit not started on accept");

  // a hand-over always reports the releasing host as prior holder
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[3:0] == ST_HANDED)) |-> m_axis_tdata[8])
    else $error("hand-over without prior holder");

  // the decision waits for the modulo unit to finish
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_DECIDE) |-> !mod_busy)
    else $error("decision while modulo still running");

endmodule

`default_nettype wire
